>>> design/utc_pkg.sv
// ============================================================================
// utc_pkg - shared types and constants of the UTF-16 text classifier
// Item and statistics structures, flag bits and the unit absorb function.
// ============================================================================
package utc_pkg;

    // Field widths
    localparam int UNIT_W = 16;
    localparam int LEN_W  = 16;
    localparam int MASK_W = 16;
    localparam int FLAG_W = 13;
    localparam int VAR_W  = 16;
    localparam int ZB_W   = 10;
    localparam int CRLF_W = 9;
    localparam int CRF_W  = CRLF_W + 1;

    // Result flag bits
    localparam logic [FLAG_W-1:0] F_ASCII16     = 13'h0001;
    localparam logic [FLAG_W-1:0] F_STATS       = 13'h0002;
    localparam logic [FLAG_W-1:0] F_CONTROLS    = 13'h0004;
    localparam logic [FLAG_W-1:0] F_SIGNATURE   = 13'h0008;
    localparam logic [FLAG_W-1:0] F_REV_ASCII16 = 13'h0010;
    localparam logic [FLAG_W-1:0] F_REV_STATS   = 13'h0020;
    localparam logic [FLAG_W-1:0] F_REV_CTRL    = 13'h0040;
    localparam logic [FLAG_W-1:0] F_REV_SIG     = 13'h0080;
    localparam logic [FLAG_W-1:0] F_ILLEGAL     = 13'h0100;
    localparam logic [FLAG_W-1:0] F_ODD_LEN     = 13'h0200;
    localparam logic [FLAG_W-1:0] F_NULL_BYTES  = 13'h1000;
    localparam logic [FLAG_W-1:0] F_SHORT       = 13'h0005;

    // Verdict masks
    localparam logic [FLAG_W-1:0] V_SIG_MASK = 13'h0B08;
    localparam logic [FLAG_W-1:0] V_SIG_ONLY = 13'h0008;
    localparam logic [FLAG_W-1:0] V_REVERSE  = 13'h00F0;
    localparam logic [FLAG_W-1:0] V_BAD      = 13'h0F00;
    localparam logic [FLAG_W-1:0] V_GOOD     = 13'h100F;

    // Unit codes
    localparam logic [UNIT_W-1:0] U_NUL     = 16'h0000;
    localparam logic [UNIT_W-1:0] U_TAB     = 16'h0009;
    localparam logic [UNIT_W-1:0] U_LF      = 16'h000A;
    localparam logic [UNIT_W-1:0] U_CR      = 16'h000D;
    localparam logic [UNIT_W-1:0] U_SPACE   = 16'h0020;
    localparam logic [UNIT_W-1:0] U_IDSP    = 16'h3000;
    localparam logic [UNIT_W-1:0] U_REV_TAB = 16'h0900;
    localparam logic [UNIT_W-1:0] U_REV_LF  = 16'h0A00;
    localparam logic [UNIT_W-1:0] U_REV_CR  = 16'h0D00;
    localparam logic [UNIT_W-1:0] U_REV_SP  = 16'h2000;
    localparam logic [UNIT_W-1:0] U_LFCR    = 16'h0A0D;
    localparam logic [UNIT_W-1:0] U_NONCHAR = 16'hFFFF;
    localparam logic [UNIT_W-1:0] U_BOM     = 16'hFEFF;
    localparam logic [UNIT_W-1:0] U_REV_BOM = 16'hFFFE;

    // Byte codes
    localparam logic [7:0] B_CR  = 8'h0D;
    localparam logic [7:0] B_LF  = 8'h0A;
    localparam logic [7:0] B_EOF = 8'h1A;

    localparam logic [VAR_W-1:0] LV_LIMIT = 16'h007F;
    localparam int CRLF_DIV = 40;

    // One unit with its precomputed classes
    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              sp;
        logic              rv;
        logic              il;
        logic              lo_cr;
        logic              lo_lf;
        logic [1:0]        zcnt;
    } t_uinfo;

    // One queued item
    typedef struct packed {
        t_uinfo            u;
        logic              last;
        logic              short_len;
        logic              len2;
        logic              drop_ok;
        logic              odd;
        logic [LEN_W-1:0]  blen;
        logic [MASK_W-1:0] ask;
        logic              masked;
    } t_item;

    // Running statistics
    typedef struct packed {
        logic [7:0]        prev_high;
        logic [7:0]        prev_low;
        logic [VAR_W-1:0]  hv;
        logic [VAR_W-1:0]  lv;
        logic [ZB_W-1:0]   zb;
        logic [CRLF_W-1:0] crlf;
        logic              sp;
        logic              rv;
        logic              il;
    } t_stats;

    // Fold one unit into the statistics
    function automatic t_stats absorb(t_stats s, t_uinfo x);
        t_stats     r;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] dh;
        logic [7:0] dl;
        r  = s;
        lo = x.unit[7:0];
        hi = x.unit[15:8];
        dh = (hi > s.prev_high) ? hi - s.prev_high : s.prev_high - hi;
        dl = (lo > s.prev_low) ? lo - s.prev_low : s.prev_low - lo;
        r.sp = s.sp | x.sp;
        r.rv = s.rv | x.rv;
        r.il = s.il | x.il;
        if ((x.lo_cr && s.prev_high == B_LF) || (x.lo_lf && s.prev_high == B_CR)) begin
            r.crlf = s.crlf + CRLF_W'(1);
        end
        r.zb        = s.zb + ZB_W'(x.zcnt);
        r.hv        = s.hv + VAR_W'(dh);
        r.lv        = s.lv + VAR_W'(dl);
        r.prev_high = hi;
        r.prev_low  = lo;
        return r;
    endfunction

endpackage

>>> design/utc_in_if.sv
// ============================================================================
// utc_in_if - input channel of the UTF-16 text classifier
// Valid/ready handshake carrying one buffer unit with its call context.
// ============================================================================
interface utc_in_if;
    import utc_pkg::*;

    logic              valid;
    logic              ready;
    logic [LEN_W-1:0]  byte_len;
    logic [UNIT_W-1:0] unit;
    logic              last_unit;
    logic [MASK_W-1:0] ask_mask;
    logic              mask_present;

    modport source (
        output valid, byte_len, unit, last_unit, ask_mask, mask_present,
        input  ready
    );
    modport sink (
        input  valid, byte_len, unit, last_unit, ask_mask, mask_present,
        output ready
    );
endinterface

>>> design/utc_out_if.sv
// ============================================================================
// utc_out_if - result channel of the UTF-16 text classifier
// Valid/ready handshake carrying the flag word and the text verdict.
// ============================================================================
interface utc_out_if;
    import utc_pkg::*;

    logic              valid;
    logic              ready;
    logic [FLAG_W-1:0] flags;
    logic              is_text;

    modport source (
        output valid, flags, is_text,
        input  ready
    );
    modport sink (
        input  valid, flags, is_text,
        output ready
    );
endinterface

>>> design/utc_queue.sv
// ============================================================================
// utc_queue - two-entry item queue
// Decouples the classifying front end from the accumulating back end.
// ============================================================================
module utc_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_pop
);
    logic [W-1:0] r_mem [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    // Store pushed item
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule

>>> design/utc_front.sv
// ============================================================================
// utc_front - input acceptance and unit classification
// Tags each unit with its character classes and the length decisions.
// ============================================================================
module utc_front #(
    parameter int MAX_UNITS = 256
) (
    utc_in_if.sink          i_in,
    input  logic            i_q_ready,
    output logic            o_push,
    output utc_pkg::t_item  o_item
);
    import utc_pkg::*;

    logic [UNIT_W-1:0] u;
    logic [LEN_W-1:0]  blen;
    logic              short_len;

    assign u         = i_in.unit;
    assign blen      = i_in.byte_len;
    assign short_len = (blen < LEN_W'(2));

    assign i_in.ready = i_q_ready;
    // Drop short-buffer items that end nothing
    assign o_push = i_in.valid & i_q_ready & (~short_len | i_in.last_unit);

    // Classify the unit and the length
    always_comb begin
        o_item.u.unit  = u;
        o_item.u.sp    = (u == U_SPACE) || (u == U_TAB) || (u == U_LF) ||
                         (u == U_CR) || (u == U_IDSP);
        o_item.u.rv    = (u == U_REV_TAB) || (u == U_REV_LF) || (u == U_REV_CR) ||
                         (u == U_REV_SP);
        o_item.u.il    = (u == U_NUL) || (u == U_LFCR) || (u == U_REV_BOM) ||
                         (u == U_NONCHAR);
        o_item.u.lo_cr = (u[7:0] == B_CR);
        o_item.u.lo_lf = (u[7:0] == B_LF);
        o_item.u.zcnt  = 2'(u[7:0] == 8'd0) + 2'(u[15:8] == 8'd0);
        o_item.last      = i_in.last_unit;
        o_item.short_len = short_len;
        o_item.len2      = (blen == LEN_W'(2));
        o_item.drop_ok   = ~blen[0] && (blen > LEN_W'(2)) &&
                           (blen[LEN_W-1:1] <= (LEN_W-1)'(MAX_UNITS));
        o_item.odd       = blen[0];
        o_item.blen      = blen;
        o_item.ask       = i_in.ask_mask;
        o_item.masked    = i_in.mask_present;
    end
endmodule

>>> design/utc_back.sv
// ============================================================================
// utc_back - statistics accumulation and verdict pipeline
// Folds units into running statistics and finishes each buffer in two stages.
// ============================================================================
module utc_back #(
    parameter int MAX_UNITS = 256,
    parameter int LEN_CAP   = 512
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  utc_pkg::t_item i_item,
    output logic           o_pop,
    utc_out_if.source      o_out
);
    import utc_pkg::*;

    localparam int CNT_W = $clog2(MAX_UNITS + 1);
    localparam int CAP_W = $clog2(LEN_CAP + 1);

    typedef struct packed {
        logic [VAR_W-1:0]  hv;
        logic [VAR_W-1:0]  lv;
        logic [CRF_W-1:0]  crlf;
        logic              nulls;
        logic              sp;
        logic              rv;
        logic              il;
        logic [CAP_W-1:0]  cap;
        logic              odd;
        logic [UNIT_W-1:0] first;
        logic [MASK_W-1:0] ask;
        logic              masked;
        logic              short_res;
    } t_fin;

    // Accumulator state
    t_stats            r_st,    n_st;
    t_uinfo            r_held,  n_held;
    logic              r_hval,  n_hval;
    logic [UNIT_W-1:0] r_first, n_first;
    logic [CNT_W-1:0]  r_cnt,   n_cnt;

    // Snapshot stage
    logic              r_s_vld;
    t_stats            r_s_st;
    t_uinfo            r_s_held;
    logic [UNIT_W-1:0] r_s_first;
    logic [CNT_W-1:0]  r_s_cnt;
    t_item             r_s_item;

    // Finish stage
    logic              r_t_vld;
    t_fin              r_t;
    t_fin              n_t;

    // Output register
    logic              r_o_vld;
    logic [FLAG_W-1:0] r_o_flags;
    logic              r_o_text;
    logic [FLAG_W-1:0] n_flags;
    logic              n_text;

    logic o_adv;
    logic t_adv;
    logic s_free;
    logic take;
    t_stats st_a;

    assign o_adv  = ~r_o_vld | o_out.ready;
    assign t_adv  = ~r_t_vld | o_adv;
    assign s_free = ~r_s_vld | t_adv;
    // Hold a last item until the snapshot stage can take it
    assign o_pop  = i_q_valid & (~i_item.last | s_free);

    assign o_out.valid   = r_o_vld;
    assign o_out.flags   = r_o_flags;
    assign o_out.is_text = r_o_text;

    // Accumulate one unit, clear at buffer end
    always_comb begin
        take    = (r_cnt < CNT_W'(MAX_UNITS));
        st_a    = r_hval ? absorb(r_st, r_held) : r_st;
        n_st    = r_st;
        n_held  = r_held;
        n_hval  = r_hval;
        n_first = r_first;
        n_cnt   = r_cnt;
        if (take) begin
            n_st    = st_a;
            n_first = r_hval ? r_first : i_item.u.unit;
            n_held  = i_item.u;
            n_hval  = 1'b1;
            n_cnt   = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= '0;
            r_hval  <= 1'b0;
            r_cnt   <= '0;
            r_held  <= '0;
            r_first <= '0;
        end else if (o_pop) begin
            if (i_item.last) begin
                r_st   <= '0;
                r_hval <= 1'b0;
                r_cnt  <= '0;
            end else if (!i_item.short_len) begin
                r_st    <= n_st;
                r_hval  <= n_hval;
                r_cnt   <= n_cnt;
                r_held  <= n_held;
                r_first <= n_first;
            end
        end
    end

    // Capture the buffer-end snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (s_free) begin
            r_s_vld <= o_pop & i_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_free && o_pop && i_item.last) begin
            r_s_st    <= n_st;
            r_s_held  <= n_held;
            r_s_first <= n_first;
            r_s_cnt   <= n_cnt;
            r_s_item  <= i_item;
        end
    end

    // Apply the trailing unit rules and end-of-buffer tests
    always_comb begin
        logic   hi_zero;
        logic   lone;
        logic   drop;
        logic   done_any;
        t_stats fs;
        hi_zero  = (r_s_held.unit[15:8] == 8'd0);
        lone     = r_s_item.len2 && (r_s_held.unit != U_NUL) && hi_zero;
        drop     = ~r_s_item.len2 && r_s_item.drop_ok && hi_zero;
        fs       = drop ? r_s_st : absorb(r_s_st, r_s_held);
        done_any = ~(drop && (r_s_cnt == CNT_W'(1)));

        n_t.crlf  = CRF_W'(fs.crlf);
        n_t.nulls = 1'b0;
        if (done_any) begin
            if ((fs.prev_low == B_CR && fs.prev_high == B_LF) ||
                (fs.prev_low == B_LF && fs.prev_high == B_CR)) begin
                n_t.crlf = n_t.crlf + CRF_W'(1);
            end
            if (fs.prev_high != 8'd0) begin
                n_t.nulls = (fs.zb != '0);
                if (fs.prev_high == B_EOF) begin
                    n_t.crlf = n_t.crlf + CRF_W'(1);
                end
            end else begin
                n_t.nulls = (fs.zb > ZB_W'(1));
            end
        end
        n_t.hv        = fs.hv;
        n_t.lv        = fs.lv;
        n_t.sp        = fs.sp;
        n_t.rv        = fs.rv;
        n_t.il        = fs.il;
        n_t.cap       = (r_s_item.blen > LEN_W'(LEN_CAP)) ? CAP_W'(LEN_CAP)
                                                           : CAP_W'(r_s_item.blen);
        n_t.odd       = r_s_item.odd;
        n_t.first     = r_s_first;
        n_t.ask       = r_s_item.ask;
        n_t.masked    = r_s_item.masked;
        n_t.short_res = r_s_item.short_len | lone;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else if (t_adv) begin
            r_t_vld <= r_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (t_adv && r_s_vld) begin
            r_t <= n_t;
        end
    end

    // Build the flag word and the verdict
    always_comb begin
        logic [VAR_W+1:0]  hv3;
        logic [VAR_W+1:0]  lv3;
        logic [LEN_W-1:0]  lim;
        logic [FLAG_W-1:0] f;
        hv3 = (VAR_W+2)'(r_t.hv) + ((VAR_W+2)'(r_t.hv) << 1);
        lv3 = (VAR_W+2)'(r_t.lv) + ((VAR_W+2)'(r_t.lv) << 1);
        lim = LEN_W'(r_t.crlf + CRF_W'(1)) * LEN_W'(CRLF_DIV);
        f   = '0;
        if (r_t.lv < LV_LIMIT) begin
            if (r_t.hv == '0) begin
                f = F_ASCII16;
            end else if (r_t.lv == '0) begin
                f = F_REV_ASCII16;
            end
        end
        if (hv3 < (VAR_W+2)'(r_t.lv)) f |= F_STATS;
        if (lv3 < (VAR_W+2)'(r_t.hv)) f |= F_REV_STATS;
        if (r_t.sp) f |= F_CONTROLS;
        if (r_t.rv) f |= F_REV_CTRL;
        if (r_t.il || ((r_t.crlf != '0) && (LEN_W'(r_t.cap) < lim))) f |= F_ILLEGAL;
        if (r_t.odd) f |= F_ODD_LEN;
        if (r_t.nulls) f |= F_NULL_BYTES;
        if (r_t.first == U_BOM) begin
            f |= F_SIGNATURE;
        end else if (r_t.first == U_REV_BOM) begin
            f |= F_REV_SIG;
        end
        if (r_t.masked) begin
            f &= r_t.ask[FLAG_W-1:0];
        end

        priority if ((f & V_SIG_MASK) == V_SIG_ONLY) begin
            n_text = 1'b1;
        end else if ((f & V_REVERSE) != '0) begin
            n_text = 1'b0;
        end else if ((f & V_BAD) != '0) begin
            n_text = 1'b0;
        end else if ((f & V_GOOD) != '0) begin
            n_text = 1'b1;
        end else begin
            n_text = 1'b0;
        end
        n_flags = f;
        if (r_t.short_res) begin
            n_flags = F_SHORT;
            n_text  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (o_adv) begin
            r_o_vld <= r_t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && r_t_vld) begin
            r_o_flags <= n_flags;
            r_o_text  <= n_text;
        end
    end
endmodule

>>> design/utf16_text_classifier.sv
// ============================================================================
// utf16_text_classifier - UTF-16 text detection heuristic
// Streams 16-bit units of a buffer and reports test flags and a text verdict.
// ============================================================================
// Usage:
//   i_in carries one little-endian unit per item together with the buffer's
//   byte length, the caller's mask and its presence bit; last_unit marks the
//   final unit of a buffer. Only the first MAX_UNITS units are counted.
//   o_out carries one result per buffer: the masked flag word and is_text.
//   Throughput: one item per cycle, sustained while o_out accepts results,
//   including back-to-back buffers. A result moves from the queue through the
//   snapshot and finish stages to the flag build into the output register.
//   A two-entry queue sits between the classifying front end and the
//   accumulating back end; when o_out stalls, the output register and the
//   pipeline stages fill, the queue backs up and i_in.ready drops.
//   Non-final units keep flowing while a result waits.
//   Reset clears all statistics, the queue and every valid flag; no result
//   is pending after reset.
// ============================================================================
module utf16_text_classifier #(
    parameter int MAX_UNITS = 256,
    parameter int LEN_CAP   = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    utc_in_if.sink     i_in,
    utc_out_if.source  o_out
);
    import utc_pkg::*;

    logic  f_push;
    t_item f_item;
    logic  q_ready;
    logic  q_valid;
    t_item q_item;
    logic  b_pop;

    // Classify accepted units
    utc_front #(
        .MAX_UNITS(MAX_UNITS)
    ) u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (f_push),
        .o_item    (f_item)
    );

    // Decouple front and back
    utc_queue #(
        .W($bits(t_item))
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_item),
        .i_pop   (b_pop)
    );

    // Accumulate and finish
    utc_back #(
        .MAX_UNITS(MAX_UNITS),
        .LEN_CAP  (LEN_CAP)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (b_pop),
        .o_out     (o_out)
    );
endmodule
